FILE: hdl/code11_barcode_encoder_macros.svh
// Assertion macros for the Code 11 encoder blocks.
// Clocked on aclk, disabled while aresetn is low; no other dependencies.
`ifndef CODE11_BARCODE_ENCODER_MACROS_SVH
`define CODE11_BARCODE_ENCODER_MACROS_SVH
`ifndef SYNTHESIS
`define C11E_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("c11e assertion failed");
`define C11E_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("c11e assertion failed");
`else
`define C11E_ASSERT_NOW(label, clk, rstn, ante, cons)
`define C11E_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

FILE: hdl/c11e_pkg.sv
// Shared types, codes and helper functions of the Code 11 encoder.
// Used by the front, back and top-level files; no dependencies.
`default_nettype none
package c11e_pkg;

    localparam int SYM_W   = 4;
    localparam int KIND_W  = 3;
    localparam int WIDTH_W = 4;
    localparam int CNT_W   = 3;
    localparam int CFG_INDEX_W = 2;

    localparam int C_SLOTS = 10;
    localparam int K_SLOTS = 9;

    localparam logic [SYM_W-1:0] SYM_HYPHEN     = 4'd10;
    localparam logic [SYM_W-1:0] PAT_START_STOP = 4'd11;
    localparam logic [SYM_W-1:0] MOD_BASE       = 4'd11;

    localparam logic [KIND_W-1:0] KIND_START = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DATA  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CCHK  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_KCHK  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_STOP  = 3'd4;

    localparam logic [CNT_W-1:0] COUNT_FULL = 3'd6;
    localparam logic [CNT_W-1:0] COUNT_STOP = 3'd5;

    localparam logic [CFG_INDEX_W-1:0] REG_NARROW = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WIDE   = 2'd1;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             last;
        logic             first;
    } queue_entry_t;

    typedef struct packed {
        logic [WIDTH_W-1:0] narrow_width;
        logic [WIDTH_W-1:0] wide_width;
    } cfg_t;

    // Wide flags for bar, space, bar, space, bar; bit 4 is the first element.
    function automatic logic [4:0] wide_flags(input logic [SYM_W-1:0] pat);
        logic [4:0] flags;
        case (pat)
            4'd0:    flags = 5'h01;
            4'd1:    flags = 5'h11;
            4'd2:    flags = 5'h09;
            4'd3:    flags = 5'h18;
            4'd4:    flags = 5'h05;
            4'd5:    flags = 5'h14;
            4'd6:    flags = 5'h0C;
            4'd7:    flags = 5'h03;
            4'd8:    flags = 5'h12;
            4'd9:    flags = 5'h10;
            4'd10:   flags = 5'h04;
            default: flags = 5'h06;
        endcase
        return flags;
    endfunction

    // Sum of two residues below eleven, reduced mod eleven.
    function automatic logic [SYM_W-1:0] add_mod11(input logic [SYM_W-1:0] a,
                                                  input logic [SYM_W-1:0] b);
        logic [SYM_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= {1'b0, MOD_BASE}) begin
            sum = sum - {1'b0, MOD_BASE};
        end
        return sum[SYM_W-1:0];
    endfunction

endpackage
`default_nettype wire

FILE: hdl/code11_barcode_encoder.sv
// Top level of the Code 11 encoder with C and K check characters.
// Instantiates c11e_front, c11e_queue and c11e_back; depends on c11e_pkg.
//
// Takes one Code 11 symbol per item (0-9, 10 hyphen, larger codes are
// treated as hyphen) and returns one result per pattern: the start pattern
// before the first symbol of a message, one data pattern per symbol, and
// after the item flagged last the C check, the K check and the stop
// pattern. The back end returns the start result for the first item of a
// message before its data result; after the last item it accumulates the
// checks (one residue slot per cycle through a term and a sum mod-11 adder
// per check) before the closing results. A queue of QUEUE_DEPTH items keeps
// the input taking items while the back end works, and a result register
// holds each result until it is taken. Width registers are written through
// cfg_we/cfg_index/cfg_wdata: index 0 narrow width, index 1 wide width.
`default_nettype none
module code11_barcode_encoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_we,
    input  wire logic [c11e_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [c11e_pkg::WIDTH_W-1:0]        cfg_wdata,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [c11e_pkg::SYM_W-1:0]          s_symbol,
    input  wire logic                                s_last,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [c11e_pkg::KIND_W-1:0]              m_kind,
    output logic [c11e_pkg::SYM_W-1:0]               m_value,
    output logic [c11e_pkg::WIDTH_W-1:0]             m_width_a,
    output logic [c11e_pkg::WIDTH_W-1:0]             m_width_b,
    output logic [c11e_pkg::WIDTH_W-1:0]             m_width_c,
    output logic [c11e_pkg::WIDTH_W-1:0]             m_width_d,
    output logic [c11e_pkg::WIDTH_W-1:0]             m_width_e,
    output logic [c11e_pkg::WIDTH_W-1:0]             m_width_f,
    output logic [c11e_pkg::CNT_W-1:0]               m_element_count,
    output logic                                     m_end_of_run
);

    localparam int ENTRY_W = $bits(c11e_pkg::queue_entry_t);

    c11e_pkg::cfg_t         cfg_reg, cfg_next;
    c11e_pkg::queue_entry_t push_entry;
    c11e_pkg::queue_entry_t head_entry;
    logic [ENTRY_W-1:0]     head_bits;
    logic                   push;
    logic                   pop;
    logic                   queue_full;
    logic                   queue_empty;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                c11e_pkg::REG_NARROW: cfg_next.narrow_width = cfg_wdata;
                c11e_pkg::REG_WIDE:   cfg_next.wide_width   = cfg_wdata;
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.narrow_width <= 4'd4;
            cfg_reg.wide_width   <= 4'd8;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    c11e_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_symbol   (s_symbol),
        .s_last     (s_last),
        .queue_full (queue_full),
        .push       (push),
        .push_entry (push_entry)
    );

    c11e_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_entry),
        .pop       (pop),
        .head_data (head_bits),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    assign head_entry = c11e_pkg::queue_entry_t'(head_bits);

    c11e_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .head            (head_entry),
        .head_empty      (queue_empty),
        .pop             (pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_value         (m_value),
        .m_width_a       (m_width_a),
        .m_width_b       (m_width_b),
        .m_width_c       (m_width_c),
        .m_width_d       (m_width_d),
        .m_width_e       (m_width_e),
        .m_width_f       (m_width_f),
        .m_element_count (m_element_count),
        .m_end_of_run    (m_end_of_run)
    );

endmodule
`default_nettype wire

FILE: hdl/c11e_front.sv
// Input side: accepts items, clamps the symbol and marks the first item
// of each message. Depends on c11e_pkg.
`default_nettype none
module c11e_front (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [c11e_pkg::SYM_W-1:0] s_symbol,
    input  wire logic                       s_last,
    input  wire logic                       queue_full,
    output logic                            push,
    output c11e_pkg::queue_entry_t          push_entry
);

    logic in_message_reg;
    logic in_message_next;

    assign s_ready = !queue_full;
    assign push    = s_valid && s_ready;

    always_comb begin
        push_entry.symbol = (s_symbol > c11e_pkg::SYM_HYPHEN) ? c11e_pkg::SYM_HYPHEN
                                                                : s_symbol;
        push_entry.last   = s_last;
        push_entry.first  = !in_message_reg;
        in_message_next   = in_message_reg;
        if (push) begin
            in_message_next = !s_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_message_reg <= 1'b0;
        end else begin
            in_message_reg <= in_message_next;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/c11e_queue.sv
// Small register queue between front and back.
// Generic width and depth; no package dependencies.
`default_nettype none
module c11e_queue #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 4
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      head_data,
    output logic                  full,
    output logic                  empty
);

    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]   mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == COUNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign head_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/c11e_back.sv
// Back end: sequences start, data, check and stop results, keeps the
// rotating residue sums and drives the result register. Depends on c11e_pkg.
`default_nettype none
`include "code11_barcode_encoder_macros.svh"
module c11e_back (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire c11e_pkg::cfg_t                cfg,
    input  wire c11e_pkg::queue_entry_t        head,
    input  wire logic                          head_empty,
    output logic                               pop,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [c11e_pkg::KIND_W-1:0]        m_kind,
    output logic [c11e_pkg::SYM_W-1:0]         m_value,
    output logic [c11e_pkg::WIDTH_W-1:0]       m_width_a,
    output logic [c11e_pkg::WIDTH_W-1:0]       m_width_b,
    output logic [c11e_pkg::WIDTH_W-1:0]       m_width_c,
    output logic [c11e_pkg::WIDTH_W-1:0]       m_width_d,
    output logic [c11e_pkg::WIDTH_W-1:0]       m_width_e,
    output logic [c11e_pkg::WIDTH_W-1:0]       m_width_f,
    output logic [c11e_pkg::CNT_W-1:0]         m_element_count,
    output logic                               m_end_of_run
);

    localparam int STEP_W = $clog2(c11e_pkg::C_SLOTS);

    typedef enum logic [2:0] {
        S_RUN,
        S_CHECK,
        S_CCHK,
        S_KCHK,
        S_STOP
    } state_t;

    state_t state_reg, state_next;
    logic   started_reg, started_next;
    logic [STEP_W-1:0] step_reg, step_next;

    logic [c11e_pkg::SYM_W-1:0] c_res_reg [c11e_pkg::C_SLOTS];
    logic [c11e_pkg::SYM_W-1:0] c_res_next [c11e_pkg::C_SLOTS];
    logic [c11e_pkg::SYM_W-1:0] k_res_reg [c11e_pkg::K_SLOTS];
    logic [c11e_pkg::SYM_W-1:0] k_res_next [c11e_pkg::K_SLOTS];

    // Horner accumulators: running term sum and weighted sum, both mod 11.
    logic [c11e_pkg::SYM_W-1:0] c_term_reg, c_term_next, c_sum_reg, c_sum_next;
    logic [c11e_pkg::SYM_W-1:0] k_term_reg, k_term_next, k_sum_reg, k_sum_next;

    logic                           out_valid_reg, out_valid_next;
    logic [c11e_pkg::KIND_W-1:0]    kind_reg, kind_next;
    logic [c11e_pkg::SYM_W-1:0]     value_reg, value_next;
    logic [c11e_pkg::WIDTH_W-1:0]   wa_reg, wb_reg, wc_reg, wd_reg, we_reg, wf_reg;
    logic [c11e_pkg::WIDTH_W-1:0]   wa_next, wb_next, wc_next, wd_next, we_next, wf_next;
    logic [c11e_pkg::CNT_W-1:0]     count_reg, count_next;
    logic                           end_reg, end_next;

    logic                           out_free;
    logic                           emit;
    logic [c11e_pkg::KIND_W-1:0]    res_kind;
    logic [c11e_pkg::SYM_W-1:0]     res_value;
    logic [c11e_pkg::SYM_W-1:0]     res_pat;
    logic                           res_stop;
    logic                           res_end;
    logic [4:0]                     flags;
    logic [c11e_pkg::SYM_W-1:0]     k_check;

    assign out_free = !out_valid_reg || m_ready;
    assign k_check  = c11e_pkg::add_mod11(k_sum_reg, c_sum_reg);

    always_comb begin
        state_next   = state_reg;
        started_next = started_reg;
        step_next    = step_reg;
        c_res_next   = c_res_reg;
        k_res_next   = k_res_reg;
        c_term_next  = c_term_reg;
        c_sum_next   = c_sum_reg;
        k_term_next  = k_term_reg;
        k_sum_next   = k_sum_reg;
        pop          = 1'b0;
        emit         = 1'b0;
        res_kind     = c11e_pkg::KIND_DATA;
        res_value    = head.symbol;
        res_pat      = head.symbol;
        res_stop     = 1'b0;
        res_end      = 1'b0;

        case (state_reg)
            S_RUN: begin
                if (!head_empty && out_free) begin
                    emit = 1'b1;
                    if (head.first && !started_reg) begin
                        res_kind     = c11e_pkg::KIND_START;
                        res_value    = '0;
                        res_pat      = c11e_pkg::PAT_START_STOP;
                        started_next = 1'b1;
                    end else begin
                        // Shift the slots down; the top slot takes the old slot 0 residue plus this symbol.
                        pop          = 1'b1;
                        res_end      = !head.last;
                        started_next = 1'b0;
                        for (int j = 0; j < c11e_pkg::C_SLOTS - 1; j++) begin
                            c_res_next[j] = c_res_reg[j+1];
                        end
                        c_res_next[c11e_pkg::C_SLOTS-1] =
                            c11e_pkg::add_mod11(c_res_reg[0], head.symbol);
                        for (int j = 0; j < c11e_pkg::K_SLOTS - 1; j++) begin
                            k_res_next[j] = k_res_reg[j+1];
                        end
                        k_res_next[c11e_pkg::K_SLOTS-1] =
                            c11e_pkg::add_mod11(k_res_reg[0], head.symbol);
                        if (head.last) begin
                            state_next  = S_CHECK;
                            step_next   = '0;
                            c_term_next = '0;
                            c_sum_next  = '0;
                            k_term_next = '0;
                            k_sum_next  = '0;
                        end
                    end
                end
            end
            S_CHECK: begin
                // Rotate the slots past a fixed tap and fold them in,
                // heaviest weight first.
                for (int j = 0; j < c11e_pkg::C_SLOTS - 1; j++) begin
                    c_res_next[j] = c_res_reg[j+1];
                end
                c_res_next[c11e_pkg::C_SLOTS-1] = c_res_reg[0];
                c_term_next = c11e_pkg::add_mod11(c_term_reg, c_res_reg[0]);
                c_sum_next  = c11e_pkg::add_mod11(c_sum_reg, c_term_next);
                if (step_reg < STEP_W'(c11e_pkg::K_SLOTS)) begin
                    for (int j = 0; j < c11e_pkg::K_SLOTS - 1; j++) begin
                        k_res_next[j] = k_res_reg[j+1];
                    end
                    k_res_next[c11e_pkg::K_SLOTS-1] = k_res_reg[0];
                    k_term_next = c11e_pkg::add_mod11(k_term_reg, k_res_reg[1]);
                    k_sum_next  = c11e_pkg::add_mod11(k_sum_reg, k_term_next);
                end
                if (step_reg == STEP_W'(c11e_pkg::C_SLOTS - 1)) begin
                    state_next = S_CCHK;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_CCHK: begin
                res_kind  = c11e_pkg::KIND_CCHK;
                res_value = c_sum_reg;
                res_pat   = c_sum_reg;
                if (out_free) begin
                    emit       = 1'b1;
                    state_next = S_KCHK;
                end
            end
            S_KCHK: begin
                res_kind  = c11e_pkg::KIND_KCHK;
                res_value = k_check;
                res_pat   = k_check;
                if (out_free) begin
                    emit       = 1'b1;
                    state_next = S_STOP;
                end
            end
            S_STOP: begin
                res_kind  = c11e_pkg::KIND_STOP;
                res_value = '0;
                res_pat   = c11e_pkg::PAT_START_STOP;
                res_stop  = 1'b1;
                res_end   = 1'b1;
                if (out_free) begin
                    emit       = 1'b1;
                    state_next = S_RUN;
                    for (int j = 0; j < c11e_pkg::C_SLOTS; j++) begin
                        c_res_next[j] = '0;
                    end
                    for (int j = 0; j < c11e_pkg::K_SLOTS; j++) begin
                        k_res_next[j] = '0;
                    end
                end
            end
            default: begin
                state_next = S_RUN;
            end
        endcase
    end

    always_comb begin
        flags          = c11e_pkg::wide_flags(res_pat);
        out_valid_next = out_valid_reg && !m_ready;
        kind_next      = kind_reg;
        value_next     = value_reg;
        wa_next        = wa_reg;
        wb_next        = wb_reg;
        wc_next        = wc_reg;
        wd_next        = wd_reg;
        we_next        = we_reg;
        wf_next        = wf_reg;
        count_next     = count_reg;
        end_next       = end_reg;
        if (emit) begin
            out_valid_next = 1'b1;
            kind_next      = res_kind;
            value_next     = res_value;
            wa_next        = flags[4] ? cfg.wide_width : cfg.narrow_width;
            wb_next        = flags[3] ? cfg.wide_width : cfg.narrow_width;
            wc_next        = flags[2] ? cfg.wide_width : cfg.narrow_width;
            wd_next        = flags[1] ? cfg.wide_width : cfg.narrow_width;
            we_next        = flags[0] ? cfg.wide_width : cfg.narrow_width;
            wf_next        = res_stop ? '0 : cfg.narrow_width;
            count_next     = res_stop ? c11e_pkg::COUNT_STOP : c11e_pkg::COUNT_FULL;
            end_next       = res_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_RUN;
            started_reg   <= 1'b0;
            step_reg      <= '0;
            c_term_reg    <= '0;
            c_sum_reg     <= '0;
            k_term_reg    <= '0;
            k_sum_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int j = 0; j < c11e_pkg::C_SLOTS; j++) begin
                c_res_reg[j] <= '0;
            end
            for (int j = 0; j < c11e_pkg::K_SLOTS; j++) begin
                k_res_reg[j] <= '0;
            end
        end else begin
            state_reg     <= state_next;
            started_reg   <= started_next;
            step_reg      <= step_next;
            c_term_reg    <= c_term_next;
            c_sum_reg     <= c_sum_next;
            k_term_reg    <= k_term_next;
            k_sum_reg     <= k_sum_next;
            out_valid_reg <= out_valid_next;
            c_res_reg     <= c_res_next;
            k_res_reg     <= k_res_next;
        end
        kind_reg  <= kind_next;
        value_reg <= value_next;
        wa_reg    <= wa_next;
        wb_reg    <= wb_next;
        wc_reg    <= wc_next;
        wd_reg    <= wd_next;
        we_reg    <= we_next;
        wf_reg    <= wf_next;
        count_reg <= count_next;
        end_reg   <= end_next;
    end

    assign m_valid         = out_valid_reg;
    assign m_kind          = kind_reg;
    assign m_value         = value_reg;
    assign m_width_a       = wa_reg;
    assign m_width_b       = wb_reg;
    assign m_width_c       = wc_reg;
    assign m_width_d       = wd_reg;
    assign m_width_e       = we_reg;
    assign m_width_f       = wf_reg;
    assign m_element_count = count_reg;
    assign m_end_of_run    = end_reg;

    `C11E_ASSERT_NOW(a_pop_nonempty, aclk, aresetn, pop, !head_empty && out_free)
    `C11E_ASSERT_NOW(a_emit_needs_room, aclk, aresetn, emit, out_free)
    `C11E_ASSERT_NEXT(a_stop_clears, aclk, aresetn, (state_reg == S_STOP) && out_free, (c_res_reg[0] == '0) && (k_res_reg[0] == '0) && (state_reg == S_RUN))
    `C11E_ASSERT_NOW(a_stop_ends_run, aclk, aresetn, out_valid_reg && (kind_reg == c11e_pkg::KIND_STOP), end_reg && (count_reg == c11e_pkg::COUNT_STOP))
    `C11E_ASSERT_NEXT(a_check_holds_out, aclk, aresetn, state_reg == S_CHECK, !emit || (state_reg == S_CCHK))

endmodule
`default_nettype wire

FILE: sim/code11_checker.sv
`timescale 1ns / 1ps
// Checker for the Code 11 encoder: follows the register port and both channels,
// predicts every result item and compares it with what the block returns. Uses c11e_pkg.
module code11_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [c11e_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [c11e_pkg::WIDTH_W-1:0]        cfg_wdata,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic [c11e_pkg::SYM_W-1:0]          s_symbol,
    input  logic                                s_last,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic [c11e_pkg::KIND_W-1:0]         m_kind,
    input  logic [c11e_pkg::SYM_W-1:0]          m_value,
    input  logic [c11e_pkg::WIDTH_W-1:0]        m_width_a,
    input  logic [c11e_pkg::WIDTH_W-1:0]        m_width_b,
    input  logic [c11e_pkg::WIDTH_W-1:0]        m_width_c,
    input  logic [c11e_pkg::WIDTH_W-1:0]        m_width_d,
    input  logic [c11e_pkg::WIDTH_W-1:0]        m_width_e,
    input  logic [c11e_pkg::WIDTH_W-1:0]        m_width_f,
    input  logic [c11e_pkg::CNT_W-1:0]          m_element_count,
    input  logic                                m_end_of_run,
    output int                                  mismatches,
    output int                                  outstanding,
    output int                                  results_checked
);

    typedef logic [c11e_pkg::SYM_W-1:0]   sym_t;
    typedef logic [c11e_pkg::WIDTH_W-1:0] width_t;
    typedef logic [c11e_pkg::KIND_W-1:0]  kind_t;

    localparam int CHECK_MOD = 11;
    localparam int C_CYCLE = 10;
    localparam int K_CYCLE = 9;
    localparam width_t NARROW_RESET = 4'd4;
    localparam width_t WIDE_RESET = 4'd8;

    typedef struct packed {
        logic [c11e_pkg::KIND_W-1:0]  kind;
        logic [c11e_pkg::SYM_W-1:0]   value;
        logic [c11e_pkg::WIDTH_W-1:0] width_a;
        logic [c11e_pkg::WIDTH_W-1:0] width_b;
        logic [c11e_pkg::WIDTH_W-1:0] width_c;
        logic [c11e_pkg::WIDTH_W-1:0] width_d;
        logic [c11e_pkg::WIDTH_W-1:0] width_e;
        logic [c11e_pkg::WIDTH_W-1:0] width_f;
        logic [c11e_pkg::CNT_W-1:0]   element_count;
        logic                         end_of_run;
    } barcode_char_t;

    barcode_char_t expected_chars[$];
    width_t        narrow_w;
    width_t        wide_w;
    logic          msg_open;
    int            pos_ten;
    int            pos_nine;
    sym_t          c_sums[C_CYCLE];
    sym_t          k_sums[K_CYCLE];

    initial begin
        mismatches = 0;
        outstanding = 0;
        results_checked = 0;
    end

    // Element widths of one character; bit 0 of the wide mask is the first bar.
    function automatic barcode_char_t char_pattern(input kind_t kind,
                                                   input sym_t val,
                                                   input sym_t pat,
                                                   input logic is_stop,
                                                   input logic run_end,
                                                   input width_t nw,
                                                   input width_t ww);
        logic [4:0]    wide;
        barcode_char_t c;
        case (pat)
            4'd0:                     wide = 5'b10000;
            4'd1:                     wide = 5'b10001;
            4'd2:                     wide = 5'b10010;
            4'd3:                     wide = 5'b00011;
            4'd4:                     wide = 5'b10100;
            4'd5:                     wide = 5'b00101;
            4'd6:                     wide = 5'b00110;
            4'd7:                     wide = 5'b11000;
            4'd8:                     wide = 5'b01001;
            4'd9:                     wide = 5'b00001;
            c11e_pkg::SYM_HYPHEN:     wide = 5'b00100;
            c11e_pkg::PAT_START_STOP: wide = 5'b01100;
            default:                  wide = 5'b01100;
        endcase
        c.kind = kind;
        c.value = val;
        c.width_a = wide[0] ? ww : nw;
        c.width_b = wide[1] ? ww : nw;
        c.width_c = wide[2] ? ww : nw;
        c.width_d = wide[3] ? ww : nw;
        c.width_e = wide[4] ? ww : nw;
        c.width_f = is_stop ? '0 : nw;
        c.element_count = is_stop ? c11e_pkg::COUNT_STOP : c11e_pkg::COUNT_FULL;
        c.end_of_run = run_end;
        return c;
    endfunction

    function automatic string describe(input barcode_char_t c);
        return $sformatf("kind=%0d value=%0d widths=%0d/%0d/%0d/%0d/%0d/%0d count=%0d end=%0d",
                         c.kind, c.value, c.width_a, c.width_b, c.width_c, c.width_d,
                         c.width_e, c.width_f, c.element_count, c.end_of_run);
    endfunction

    task automatic clear_message();
        msg_open = 1'b0;
        pos_ten = 0;
        pos_nine = 0;
        for (int r = 0; r < C_CYCLE; r++) c_sums[r] = '0;
        for (int r = 0; r < K_CYCLE; r++) k_sums[r] = '0;
    endtask

    // Queue the results one accepted item causes and advance the check sums.
    task automatic encode_symbol(input sym_t sym_in, input logic is_last);
        sym_t sym;
        int   csum;
        int   ksum;
        sym_t c_digit;
        sym_t k_digit;
        sym = (sym_in > c11e_pkg::SYM_HYPHEN) ? c11e_pkg::SYM_HYPHEN : sym_in;
        if (!msg_open) begin
            expected_chars.push_back(char_pattern(c11e_pkg::KIND_START, '0,
                                                  c11e_pkg::PAT_START_STOP, 1'b0, 1'b0,
                                                  narrow_w, wide_w));
            msg_open = 1'b1;
        end
        c_sums[pos_ten] = sym_t'((int'(c_sums[pos_ten]) + int'(sym)) % CHECK_MOD);
        k_sums[pos_nine] = sym_t'((int'(k_sums[pos_nine]) + int'(sym)) % CHECK_MOD);
        pos_ten = (pos_ten + 1) % C_CYCLE;
        pos_nine = (pos_nine + 1) % K_CYCLE;
        expected_chars.push_back(char_pattern(c11e_pkg::KIND_DATA, sym, sym, 1'b0, !is_last,
                                              narrow_w, wide_w));
        if (is_last) begin
            // Weights count from the right: the newest residue slot has weight one.
            csum = 0;
            for (int r = 0; r < C_CYCLE; r++)
                csum += int'(c_sums[r]) * (((pos_ten + C_CYCLE - 1 - r) % C_CYCLE) + 1);
            c_digit = sym_t'(csum % CHECK_MOD);
            // C itself sits at the right end of the K sum with weight one.
            ksum = int'(c_digit);
            for (int r = 0; r < K_CYCLE; r++)
                ksum += int'(k_sums[r]) * (((pos_nine + K_CYCLE - r) % K_CYCLE) + 1);
            k_digit = sym_t'(ksum % CHECK_MOD);
            expected_chars.push_back(char_pattern(c11e_pkg::KIND_CCHK, c_digit, c_digit,
                                                  1'b0, 1'b0, narrow_w, wide_w));
            expected_chars.push_back(char_pattern(c11e_pkg::KIND_KCHK, k_digit, k_digit,
                                                  1'b0, 1'b0, narrow_w, wide_w));
            expected_chars.push_back(char_pattern(c11e_pkg::KIND_STOP, '0,
                                                  c11e_pkg::PAT_START_STOP, 1'b1, 1'b1,
                                                  narrow_w, wide_w));
            clear_message();
        end
    endtask

    always @(posedge aclk) begin : track
        barcode_char_t got;
        barcode_char_t want;
        if (!aresetn) begin
            narrow_w = NARROW_RESET;
            wide_w = WIDE_RESET;
            clear_message();
            expected_chars.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    c11e_pkg::REG_NARROW: narrow_w = cfg_wdata;
                    c11e_pkg::REG_WIDE:   wide_w = cfg_wdata;
                    default:              ;
                endcase
            end
            if (s_valid && s_ready) encode_symbol(s_symbol, s_last);
            if (m_valid && m_ready) begin
                got.kind = m_kind;
                got.value = m_value;
                got.width_a = m_width_a;
                got.width_b = m_width_b;
                got.width_c = m_width_c;
                got.width_d = m_width_d;
                got.width_e = m_width_e;
                got.width_f = m_width_f;
                got.element_count = m_element_count;
                got.end_of_run = m_end_of_run;
                if (expected_chars.size() == 0) begin
                    mismatches++;
                    $display("%0t: result item with nothing expected: %s",
                             $time, describe(got));
                end else begin
                    want = expected_chars.pop_front();
                    results_checked++;
                    if (got !== want) begin
                        mismatches++;
                        $display("%0t: result mismatch: expected %s, got %s",
                                 $time, describe(want), describe(got));
                    end
                end
            end
        end
        outstanding = expected_chars.size();
    end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// Top of the Code 11 encoder testbench: clock, reset, register writes and both
// channel drivers. Depends on c11e_pkg, code11_barcode_encoder and code11_checker.
module tb_top;

    typedef logic [c11e_pkg::SYM_W-1:0]       sym_t;
    typedef logic [c11e_pkg::WIDTH_W-1:0]     width_t;
    typedef logic [c11e_pkg::CFG_INDEX_W-1:0] cfg_index_t;

    localparam int CYCLE_LIMIT = 800000;
    localparam int RANDOM_ITEMS = 480;
    localparam int DRAIN_CYCLES = 24;
    localparam int LONG_HOLD = 150;
    localparam int PRESSURE_PHASE = 3;
    localparam cfg_index_t REG_SPARE_2 = 2'd2;
    localparam cfg_index_t REG_SPARE_3 = 2'd3;

    typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_SPARSE} rx_mode_t;

    logic                                aclk;
    logic                                aresetn;
    logic                                cfg_we;
    logic [c11e_pkg::CFG_INDEX_W-1:0]    cfg_index;
    logic [c11e_pkg::WIDTH_W-1:0]        cfg_wdata;
    logic                                s_valid;
    logic                                s_ready;
    logic [c11e_pkg::SYM_W-1:0]          s_symbol;
    logic                                s_last;
    logic                                m_valid;
    logic                                m_ready;
    logic [c11e_pkg::KIND_W-1:0]         m_kind;
    logic [c11e_pkg::SYM_W-1:0]          m_value;
    logic [c11e_pkg::WIDTH_W-1:0]        m_width_a;
    logic [c11e_pkg::WIDTH_W-1:0]        m_width_b;
    logic [c11e_pkg::WIDTH_W-1:0]        m_width_c;
    logic [c11e_pkg::WIDTH_W-1:0]        m_width_d;
    logic [c11e_pkg::WIDTH_W-1:0]        m_width_e;
    logic [c11e_pkg::WIDTH_W-1:0]        m_width_f;
    logic [c11e_pkg::CNT_W-1:0]          m_element_count;
    logic                                m_end_of_run;

    int mismatches;
    int outstanding;
    int results_checked;

    rx_mode_t    rx_mode = RX_ALWAYS;
    logic [15:0] rx_pattern = 16'hffff;
    int          rx_phase = 0;
    logic        hold_request = 1'b0;
    int          hold_left = 0;
    bit          use_bursts = 0;
    int          burst_left = 0;
    int          items_sent = 0;
    int          messages_sent = 0;
    int          reg_writes = 0;
    int          phase_count = 0;
    int          cycle_count = 0;

    code11_barcode_encoder dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_symbol        (s_symbol),
        .s_last          (s_last),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_value         (m_value),
        .m_width_a       (m_width_a),
        .m_width_b       (m_width_b),
        .m_width_c       (m_width_c),
        .m_width_d       (m_width_d),
        .m_width_e       (m_width_e),
        .m_width_f       (m_width_f),
        .m_element_count (m_element_count),
        .m_end_of_run    (m_end_of_run)
    );

    code11_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_symbol        (s_symbol),
        .s_last          (s_last),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_value         (m_value),
        .m_width_a       (m_width_a),
        .m_width_b       (m_width_b),
        .m_width_c       (m_width_c),
        .m_width_d       (m_width_d),
        .m_width_e       (m_width_e),
        .m_width_f       (m_width_f),
        .m_element_count (m_element_count),
        .m_end_of_run    (m_end_of_run),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .results_checked (results_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d results still expected", cycle_count, outstanding);
        $display("Test completed with failures");
        $finish;
    end

    // Receiver: long hold-off on request, otherwise the current stall pattern.
    always begin : rx_drive
        @(negedge aclk);
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS:  m_ready <= 1'b1;
                RX_RANDOM:  m_ready <= ($urandom_range(0, 99) < 65);
                RX_PATTERN: begin
                    m_ready <= rx_pattern[rx_phase];
                    rx_phase = (rx_phase + 1) % 16;
                end
                default:    m_ready <= ($urandom_range(0, 99) < 15);
            endcase
        end
    end

    // Offer one item from a falling edge; return after acceptance and any burst gap.
    task automatic send_symbol(input sym_t sym, input logic lst);
        int gap;
        s_valid <= 1'b1;
        s_symbol <= sym;
        s_last <= lst;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        items_sent++;
        if (lst) messages_sent++;
        if (use_bursts) begin
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 30) : $urandom_range(1, 6);
                burst_left = $urandom_range(0, 11);
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end else begin
                burst_left--;
            end
        end
    endtask

    // Drop valid and hold until every expected result has come out.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input width_t val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
        reg_writes++;
    endtask

    task automatic set_receiver(input rx_mode_t mode, input bit long_hold);
        @(posedge aclk);
        rx_mode = mode;
        // Keep at least one ready slot in the pattern.
        rx_pattern = 16'($urandom) | 16'h0001;
        if (long_hold) hold_request = 1'b1;
        @(negedge aclk);
    endtask

    initial begin : main
        int   random_sent;
        int   phase_len;
        int   last_odds;
        sym_t sym;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_symbol = '0;
        s_last = 1'b0;
        m_ready = 1'b0;
        random_sent = 0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: every character at reset widths, then the corner cases.
        set_receiver(RX_ALWAYS, 0);
        for (int s = 0; s <= c11e_pkg::SYM_HYPHEN; s++)
            send_symbol(sym_t'(s), s == c11e_pkg::SYM_HYPHEN);
        send_symbol(4'd15, 1'b1);
        send_symbol(4'd11, 1'b0);
        send_symbol(4'd12, 1'b0);
        send_symbol(4'd13, 1'b0);
        send_symbol(4'd14, 1'b1);
        send_symbol(4'd0, 1'b1);
        // Width change in the middle of a message.
        send_symbol(4'd5, 1'b0);
        send_symbol(4'd7, 1'b0);
        wait_idle();
        write_reg(c11e_pkg::REG_NARROW, 4'd1);
        write_reg(c11e_pkg::REG_WIDE, 4'd15);
        send_symbol(4'd3, 1'b1);
        wait_idle();
        write_reg(c11e_pkg::REG_NARROW, 4'd0);
        write_reg(c11e_pkg::REG_WIDE, 4'd0);
        send_symbol(4'd9, 1'b0);
        send_symbol(c11e_pkg::SYM_HYPHEN, 1'b1);
        wait_idle();
        // Writes to indexes past the list must change nothing.
        write_reg(REG_SPARE_2, 4'd15);
        write_reg(REG_SPARE_3, 4'd0);
        write_reg(c11e_pkg::REG_NARROW, 4'd15);
        write_reg(c11e_pkg::REG_WIDE, 4'd1);
        send_symbol(4'd1, 1'b0);
        send_symbol(4'd8, 1'b1);

        // Random phases; a phase may end mid-message, so writes also land mid-message.
        while (random_sent < RANDOM_ITEMS) begin
            phase_count++;
            wait_idle();
            case ($urandom_range(0, 5))
                0: begin
                    write_reg(c11e_pkg::REG_NARROW, 4'd4);
                    write_reg(c11e_pkg::REG_WIDE, 4'd8);
                end
                1: begin
                    write_reg(c11e_pkg::REG_NARROW, 4'd1);
                    write_reg(c11e_pkg::REG_WIDE, 4'd15);
                end
                2: begin
                    write_reg(c11e_pkg::REG_NARROW, 4'd15);
                    write_reg(c11e_pkg::REG_WIDE, 4'd1);
                end
                default: begin
                    write_reg(c11e_pkg::REG_NARROW, width_t'($urandom_range(0, 15)));
                    write_reg(c11e_pkg::REG_WIDE, width_t'($urandom_range(0, 15)));
                end
            endcase
            if ($urandom_range(0, 3) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                          width_t'($urandom_range(0, 15)));
            if (phase_count == PRESSURE_PHASE) begin
                // Fill the block against a stalled receiver.
                use_bursts = 0;
                set_receiver(RX_ALWAYS, 1);
                phase_len = 40;
            end else begin
                use_bursts = ($urandom_range(0, 3) != 0);
                burst_left = $urandom_range(0, 11);
                set_receiver(rx_mode_t'($urandom_range(0, 3)), 0);
                phase_len = $urandom_range(8, 40);
            end
            case ($urandom_range(0, 2))
                0:       last_odds = 2;
                1:       last_odds = 6;
                default: last_odds = 30;
            endcase
            for (int k = 0; k < phase_len; k++) begin
                if ($urandom_range(0, 4) == 0)
                    sym = sym_t'($urandom_range(0, 15));
                else
                    sym = sym_t'($urandom_range(0, 10));
                send_symbol(sym, $urandom_range(1, last_odds) == 1);
                random_sent++;
            end
        end
        // Close any open message.
        send_symbol(sym_t'($urandom_range(0, 10)), 1'b1);
        wait_idle();

        $display("Sent %0d items in %0d messages over %0d random phases", items_sent,
                 messages_sent, phase_count);
        $display("Checked %0d result items under %0d register writes", results_checked,
                 reg_writes);
        if (mismatches == 0 && outstanding == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hdl
hdl/c11e_pkg.sv
hdl/c11e_front.sv
hdl/c11e_queue.sv
hdl/c11e_back.sv
hdl/code11_barcode_encoder.sv
sim/code11_checker.sv
sim/tb_top.sv
